[hw/rtl/lfsc_pkg.sv]
// Line-follow steering controller: shared types, widths, register indexes and reset values.
// No dependencies; every other file of the block imports this package.
package lfsc_pkg;

    localparam int RD_W                 = 8;
    localparam int SPEED_W              = 8;
    localparam int GAIN_W               = 8;
    localparam int ERR_W                = RD_W + 1;
    localparam int CFG_IDX_W            = 2;
    localparam int WINDOW_LEN_DEFAULT   = 5;
    localparam int QUEUE_DEPTH          = 2;
    localparam int BACK_STAGES          = 4;
    // Gains are in hundredths
    localparam int SCALE                = 100;
    // Largest |numerator| per window entry: 255*(255 + 510 + 255) + 100*255
    localparam int PER_W_MAX            = 285600;
    // Quotient magnitude never exceeds PER_W_MAX / SCALE = 2856
    localparam int QUOT_W               = 12;

    localparam logic [GAIN_W-1:0] BASE_SPEED_RST = 8'd45;
    localparam logic [GAIN_W-1:0] P_GAIN_RST     = 8'd20;
    localparam logic [GAIN_W-1:0] I_GAIN_RST     = 8'd5;
    localparam logic [GAIN_W-1:0] AVG_GAIN_RST   = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_SPEED = 2'd0,
        REG_P_GAIN     = 2'd1,
        REG_I_GAIN     = 2'd2,
        REG_AVG_GAIN   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] base_speed;
        logic [GAIN_W-1:0] p_gain;
        logic [GAIN_W-1:0] i_gain;
        logic [GAIN_W-1:0] avg_gain;
    } gains_t;

endpackage

[hw/rtl/lfsc_in_if.sv]
// Sensor channel: valid/ready handshake carrying one pair of line-sensor readings.
// Depends on lfsc_pkg for the field width.
interface lfsc_in_if;
    import lfsc_pkg::*;

    logic            valid;
    logic            ready;
    logic [RD_W-1:0] left_reading;
    logic [RD_W-1:0] right_reading;

    modport source (output valid, output left_reading, output right_reading, input ready);
    modport sink   (input valid, input left_reading, input right_reading, output ready);
endinterface

[hw/rtl/lfsc_out_if.sv]
// Speed channel: valid/ready handshake carrying one pair of wheel speed commands.
// Depends on lfsc_pkg for the field width.
interface lfsc_out_if;
    import lfsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;

    modport source (output valid, output left_speed, output right_speed, input ready);
    modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

[hw/rtl/lfsc_front.sv]
// Front end: accepts sensor beats, forms the error, keeps the error window and running sum.
// Depends on lfsc_pkg and lfsc_in_if; pushes one entry per beat into lfsc_queue.
module lfsc_front #(
    parameter int WINDOW_LEN = lfsc_pkg::WINDOW_LEN_DEFAULT,
    parameter int SUM_W      = lfsc_pkg::ERR_W + $clog2(lfsc_pkg::WINDOW_LEN_DEFAULT)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    lfsc_in_if.sink                                sensor,
    input  logic                                   q_full,
    output logic                                   q_push,
    output logic [2*lfsc_pkg::ERR_W+SUM_W-1:0]     q_data
);
    import lfsc_pkg::*;

    logic signed [ERR_W-1:0] window_reg [WINDOW_LEN];
    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [ERR_W-1:0] err;

    assign sensor.ready = !q_full;
    assign q_push       = sensor.valid && !q_full;

    assign err      = $signed({1'b0, sensor.left_reading}) - $signed({1'b0, sensor.right_reading});
    // Add the newest error, drop the one that falls off the end of the window
    assign sum_next = sum_reg + SUM_W'(err) - SUM_W'(window_reg[WINDOW_LEN-1]);

    assign q_data = {err, prev_err_reg, sum_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_LEN; k++)
            begin
                window_reg[k] <= '0;
            end
            prev_err_reg <= '0;
            sum_reg      <= '0;
        end
        else if (q_push)
        begin
            for (int k = WINDOW_LEN - 1; k > 0; k--)
            begin
                window_reg[k] <= window_reg[k-1];
            end
            window_reg[0] <= err;
            prev_err_reg  <= err;
            sum_reg       <= sum_next;
        end
    end

endmodule

[hw/rtl/lfsc_queue.sv]
// Short queue between front and back end, so each side can stall on its own.
// Depends on lfsc_pkg for the default depth.
module lfsc_queue #(
    parameter int DEPTH  = lfsc_pkg::QUEUE_DEPTH,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              avail,
    output logic [DATA_W-1:0] pop_data
);
    import lfsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign avail    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/lfsc_back.sv]
// Back end: four-stage pipeline computing the steering term and both wheel speeds.
// Depends on lfsc_pkg and lfsc_out_if; pops entries from lfsc_queue.
module lfsc_back #(
    parameter int WINDOW_LEN = lfsc_pkg::WINDOW_LEN_DEFAULT,
    parameter int SUM_W      = lfsc_pkg::ERR_W + $clog2(lfsc_pkg::WINDOW_LEN_DEFAULT)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lfsc_pkg::gains_t                       gains,
    input  logic                                   q_avail,
    input  logic [2*lfsc_pkg::ERR_W+SUM_W-1:0]     q_data,
    output logic                                   q_pop,
    lfsc_out_if.source                             speed
);
    import lfsc_pkg::*;

    localparam int DENOM   = SCALE * WINDOW_LEN;
    localparam int MAG_W   = $clog2(WINDOW_LEN * PER_W_MAX + 1);
    localparam int NUM_W   = MAG_W + 1;
    localparam int RECIP   = (1 << MAG_W) / DENOM;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PE_W    = 2 * ERR_W;
    localparam int IE_W    = 2 * ERR_W + 1;
    localparam int AS_W    = SUM_W + ERR_W;

    localparam logic signed [NUM_W-1:0] W_S     = NUM_W'(WINDOW_LEN);
    localparam logic signed [NUM_W-1:0] DENOM_S = NUM_W'(DENOM);
    localparam logic [RECIP_W-1:0]      RECIP_U = RECIP_W'(RECIP);
    localparam logic [MAG_W-1:0]        DENOM_M = MAG_W'(DENOM);

    // Unpack queue entry
    logic signed [ERR_W-1:0] q_err, q_prev;
    logic signed [SUM_W-1:0] q_sum;
    assign {q_err, q_prev, q_sum} = q_data;

    // Stage valids and advance chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4  = !v4_reg || speed.ready;
    assign adv3  = !v3_reg || adv4;
    assign adv2  = !v2_reg || adv3;
    assign adv1  = !v1_reg || adv2;
    assign q_pop = q_avail && adv1;

    // Stage 1: the three gain products
    logic signed [ERR_W:0]    esum;
    logic signed [PE_W-1:0]   pe_reg, pe_next;
    logic signed [IE_W-1:0]   ie_reg, ie_next;
    logic signed [AS_W-1:0]   as_reg, as_next;

    assign esum    = $signed({q_err[ERR_W-1], q_err}) + $signed({q_prev[ERR_W-1], q_prev});
    assign pe_next = $signed({1'b0, gains.p_gain}) * q_err;
    assign ie_next = $signed({1'b0, gains.i_gain}) * esum;
    assign as_next = $signed({1'b0, gains.avg_gain}) * q_sum;

    // Stage 2: scaled numerators for both wheels
    logic signed [NUM_W-1:0] lin, n_term, base_scaled;
    logic signed [NUM_W-1:0] num_reg  [2];
    logic signed [NUM_W-1:0] num_next [2];

    assign lin         = NUM_W'(pe_reg) + NUM_W'(ie_reg);
    assign n_term      = lin * W_S + NUM_W'(as_reg);
    assign base_scaled = $signed(NUM_W'(gains.base_speed)) * DENOM_S;
    assign num_next[0] = base_scaled + n_term;
    assign num_next[1] = base_scaled - n_term;

    // Stage 3: magnitude and reciprocal estimate of the quotient
    logic [MAG_W-1:0]         mag_next  [2];
    logic [MAG_W-1:0]         mag_reg   [2];
    logic [MAG_W+RECIP_W-1:0] prod_next [2];
    logic [QUOT_W-1:0]        qe_reg    [2];
    logic                     neg_reg   [2];

    // Stage 4: one correction step, sign and wrap
    logic [MAG_W-1:0]   back_prod [2];
    logic [MAG_W-1:0]   rem       [2];
    logic [QUOT_W-1:0]  quot      [2];
    logic [SPEED_W-1:0] res       [2];
    logic [SPEED_W-1:0] speed_reg [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag_next[l]  = num_reg[l][NUM_W-1] ? MAG_W'(-num_reg[l]) : MAG_W'(num_reg[l]);
            prod_next[l] = (MAG_W+RECIP_W)'(mag_next[l]) * (MAG_W+RECIP_W)'(RECIP_U);
            back_prod[l] = MAG_W'(qe_reg[l]) * DENOM_M;
            rem[l]       = mag_reg[l] - back_prod[l];
            quot[l]      = qe_reg[l] + QUOT_W'(rem[l] >= DENOM_M);
            res[l]       = neg_reg[l] ? SPEED_W'(~quot[l][SPEED_W-1:0] + 1'b1)
                                      : quot[l][SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= q_avail;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && q_avail)
        begin
            pe_reg <= pe_next;
            ie_reg <= ie_next;
            as_reg <= as_next;
        end
        if (adv2 && v1_reg)
        begin
            num_reg[0] <= num_next[0];
            num_reg[1] <= num_next[1];
        end
        if (adv3 && v2_reg)
        begin
            for (int l = 0; l < 2; l++)
            begin
                mag_reg[l] <= mag_next[l];
                qe_reg[l]  <= QUOT_W'(prod_next[l] >> MAG_W);
                neg_reg[l] <= num_reg[l][NUM_W-1];
            end
        end
        if (adv4 && v3_reg)
        begin
            speed_reg[0] <= res[0];
            speed_reg[1] <= res[1];
        end
    end

    assign speed.valid       = v4_reg;
    assign speed.left_speed  = speed_reg[0];
    assign speed.right_speed = speed_reg[1];

endmodule

[hw/rtl/line_follow_steering_controller.sv]
// Top level of the line-follow steering controller: configuration registers and the
// front end, queue and back end. Depends on lfsc_pkg, lfsc_in_if, lfsc_out_if,
// lfsc_front, lfsc_queue and lfsc_back.
//
//   Channel  | Role   | Payload                        | Handshake
//   ---------+--------+--------------------------------+----------------------------
//   sensor   | sink   | left_reading, right_reading    | valid/ready, beat on both high
//   speed    | source | left_speed, right_speed        | valid/ready, beat on both high
//   cfg      | write  | cfg_index, cfg_wdata           | cfg_we, no wait, no read-back
//
// One sensor beat per cycle is sustained while speed beats are taken; each yields one
// speed beat, registered in turn (queue slot, gain products, numerators, reciprocal
// estimate, correction). The back-end pipeline keeps one multiplier stage between
// registers; the running window sum in the front end keeps the window at one add.
// Reset clears the error window, running sum, previous error, queue and pipeline valids,
// and loads the gain registers with their defaults. A stalled speed channel holds the
// output register; the pipeline and two-entry queue fill before sensor ready drops.
module line_follow_steering_controller #(
    parameter int WINDOW_LEN = lfsc_pkg::WINDOW_LEN_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lfsc_in_if.sink                         sensor,
    lfsc_out_if.source                      speed,
    input  logic                            cfg_we,
    input  logic [lfsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfsc_pkg::GAIN_W-1:0]     cfg_wdata
);
    import lfsc_pkg::*;

    // Running sum spans WINDOW_LEN errors of ERR_W bits each
    localparam int SUM_W  = ERR_W + $clog2(WINDOW_LEN);
    localparam int DATA_W = 2 * ERR_W + SUM_W;

    gains_t gains_reg;

    // Configuration writes: take the beat at once, ignore nothing since every index maps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.base_speed <= BASE_SPEED_RST;
            gains_reg.p_gain     <= P_GAIN_RST;
            gains_reg.i_gain     <= I_GAIN_RST;
            gains_reg.avg_gain   <= AVG_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BASE_SPEED: gains_reg.base_speed <= cfg_wdata;
                REG_P_GAIN:     gains_reg.p_gain     <= cfg_wdata;
                REG_I_GAIN:     gains_reg.i_gain     <= cfg_wdata;
                REG_AVG_GAIN:   gains_reg.avg_gain   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Front end to queue
    logic              q_push, q_full, q_pop, q_avail;
    logic [DATA_W-1:0] q_wdata, q_rdata;

    lfsc_front #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sensor (sensor),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    // Decouple the two halves: hold up to QUEUE_DEPTH front-end entries
    lfsc_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_data  (q_rdata)
    );

    // Back end: steering term, divide by scale times window length and wrap to wheel speeds
    lfsc_back #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .gains   (gains_reg),
        .q_avail (q_avail),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .speed   (speed)
    );

endmodule

[hw/rtl/lfsc_checker.sv]
// Port-level checker for the line-follow steering controller, with its bind statement.
// Depends on lfsc_pkg and binds to line_follow_steering_controller.
module lfsc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [lfsc_pkg::SPEED_W-1:0]    left_speed,
    input logic [lfsc_pkg::SPEED_W-1:0]    right_speed
);
    import lfsc_pkg::*;

    localparam int CAPACITY = QUEUE_DEPTH + BACK_STAGES;
    localparam int OUT_W    = $clog2(CAPACITY + 2);

    logic             in_beat, out_beat;
    logic [OUT_W-1:0] pending_reg;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Track beats taken in but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_beat && !out_beat)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("speed beat offered with no sensor beat outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= OUT_W'(CAPACITY))
        else $error("more beats in flight than queue and pipeline can hold");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> pending_reg >= OUT_W'(QUEUE_DEPTH))
        else $error("sensor ready dropped while queue cannot be full");

    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && pending_reg == '0 |=> !out_valid)
        else $error("speed beat appeared one cycle after an idle accept");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_speed) && $stable(right_speed))
        else $error("stalled speed beat changed or vanished");

endmodule

bind line_follow_steering_controller lfsc_checker u_lfsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sensor.valid),
    .in_ready    (sensor.ready),
    .out_valid   (speed.valid),
    .out_ready   (speed.ready),
    .left_speed  (speed.left_speed),
    .right_speed (speed.right_speed)
);

[test/lfsc_speed_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the line-follow steering controller. It watches the sensor, speed and
// register-write ports, predicts each speed beat and compares the beats in order.
// Depends on lfsc_pkg.
module lfsc_speed_checker
    import lfsc_pkg::*;
#(
    parameter int WINDOW = WINDOW_LEN_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [RD_W-1:0]      in_left,
    input  logic [RD_W-1:0]      in_right,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [SPEED_W-1:0]   out_left,
    input  logic [SPEED_W-1:0]   out_right,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_wdata,
    output int                   fail_count,
    output int                   outstanding,
    output int                   results_checked
);

    typedef struct packed {
        logic [SPEED_W-1:0] left;
        logic [SPEED_W-1:0] right;
    } speed_pair_t;

    logic [GAIN_W-1:0]       base_speed;
    logic [GAIN_W-1:0]       p_gain;
    logic [GAIN_W-1:0]       i_gain;
    logic [GAIN_W-1:0]       avg_gain;
    logic signed [ERR_W-1:0] err_hist [WINDOW];
    logic signed [ERR_W-1:0] last_err;
    speed_pair_t             expected_speeds [$];

    // Expects the new error already shifted into err_hist; last_err still holds the old one.
    function automatic speed_pair_t predict_speeds(input logic signed [ERR_W-1:0] err);
        longint      e;
        longint      pe;
        longint      window_sum;
        longint      denom;
        longint      steer_num;
        longint      scaled_base;
        longint      wheel;
        speed_pair_t pair;
        e          = longint'(err);
        pe         = longint'(last_err);
        window_sum = 0;
        for (int k = 0; k < WINDOW; k++)
        begin
            window_sum += longint'(err_hist[k]);
        end
        denom       = longint'(SCALE) * WINDOW;
        steer_num   = WINDOW * (longint'(p_gain) * e + longint'(i_gain) * (e + pe))
                      + longint'(avg_gain) * window_sum;
        scaled_base = denom * longint'(base_speed);
        // Integer division truncates toward zero; keep the low byte
        wheel       = (scaled_base + steer_num) / denom;
        pair.left   = wheel[SPEED_W-1:0];
        wheel       = (scaled_base - steer_num) / denom;
        pair.right  = wheel[SPEED_W-1:0];
        return pair;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [ERR_W-1:0] err;
        speed_pair_t             want;
        if (!rst_n)
        begin
            base_speed = BASE_SPEED_RST;
            p_gain     = P_GAIN_RST;
            i_gain     = I_GAIN_RST;
            avg_gain   = AVG_GAIN_RST;
            for (int k = 0; k < WINDOW; k++)
            begin
                err_hist[k] = '0;
            end
            last_err = '0;
            expected_speeds.delete();
            outstanding     = 0;
            fail_count      = 0;
            results_checked = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                err = $signed({1'b0, in_left}) - $signed({1'b0, in_right});
                for (int k = WINDOW - 1; k > 0; k--)
                begin
                    err_hist[k] = err_hist[k-1];
                end
                err_hist[0] = err;
                expected_speeds.push_back(predict_speeds(err));
                last_err = err;
            end
            if (out_valid && out_ready)
            begin
                if (expected_speeds.size() == 0)
                begin
                    $display("%0t: unexpected speed beat, left_speed %0d right_speed %0d",
                             $time, out_left, out_right);
                    fail_count++;
                end
                else
                begin
                    want = expected_speeds.pop_front();
                    results_checked++;
                    if (out_left !== want.left)
                    begin
                        $display("%0t: left_speed mismatch, expected %0d, got %0d",
                                 $time, want.left, out_left);
                        fail_count++;
                    end
                    if (out_right !== want.right)
                    begin
                        $display("%0t: right_speed mismatch, expected %0d, got %0d",
                                 $time, want.right, out_right);
                        fail_count++;
                    end
                end
            end
            // Register writes land after this edge's sensor beat is predicted
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BASE_SPEED: base_speed = cfg_wdata;
                    REG_P_GAIN:     p_gain     = cfg_wdata;
                    REG_I_GAIN:     i_gain     = cfg_wdata;
                    REG_AVG_GAIN:   avg_gain   = cfg_wdata;
                    default:        ;
                endcase
            end
            outstanding = expected_speeds.size();
        end
    end

endmodule

[test/tb_line_follow_steering_controller.sv]
`timescale 1ns / 1ps
// Testbench top for the line-follow steering controller: drives sensor beats, register
// writes and speed-channel back-pressure, and reports the verdict.
// Depends on lfsc_pkg, lfsc_in_if, lfsc_out_if, the block and lfsc_speed_checker.
module tb_line_follow_steering_controller;
    import lfsc_pkg::*;

    localparam int LONG_HOLD     = 300;  // cycles the speed channel is held off once
    localparam int SETTLE_CYCLES = 8;    // pipeline depth plus margin before a write
    localparam int STALL_LIMIT   = 4000; // cycles without any beat before giving up
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASES        = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_wdata;

    int fail_count;
    int outstanding;
    int results_checked;
    int sent_beats;
    int gain_settings;
    int idle_cycles;
    int track_offset;

    // Idling switches set by the main process and read by the sender and the receiver process
    bit tx_bursty;
    bit rx_bursty;
    bit hold_req;

    lfsc_in_if  sensor_ch ();
    lfsc_out_if speed_ch ();

    line_follow_steering_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sensor    (sensor_ch),
        .speed     (speed_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lfsc_speed_checker speed_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (sensor_ch.valid),
        .in_ready        (sensor_ch.ready),
        .in_left         (sensor_ch.left_reading),
        .in_right        (sensor_ch.right_reading),
        .out_valid       (speed_ch.valid),
        .out_ready       (speed_ch.ready),
        .out_left        (speed_ch.left_speed),
        .out_right       (speed_ch.right_speed),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Speed-channel receiver. Drop ready in short random bursts while rx_bursty is set;
    // on hold_req, hold it low long enough for the pipeline and queue to fill up, so that
    // the block has to stall the sensor channel.
    initial
    begin
        speed_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                speed_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                speed_ch.ready <= 1'b1;
                hold_req = 1'b0;
            end
            else if (rx_bursty && $urandom_range(0, 5) == 0)
            begin
                speed_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                speed_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((sensor_ch.valid && sensor_ch.ready) || (speed_ch.valid && speed_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one sensor beat and return at the edge that accepts it. Sample ready at the
    // falling edge, where it has settled, so acceptance never hinges on event order.
    // Valid stays high on return; the next call either reloads it or opens a gap.
    task automatic send_reading(input logic [RD_W-1:0] lft, input logic [RD_W-1:0] rgt);
        bit took;
        if (tx_bursty && $urandom_range(0, 4) == 0)
        begin
            sensor_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        sensor_ch.valid         <= 1'b1;
        sensor_ch.left_reading  <= lft;
        sensor_ch.right_reading <= rgt;
        do
        begin
            @(negedge clk);
            took = sensor_ch.ready;
            @(posedge clk);
        end
        while (!took);
        sent_beats++;
    endtask

    // Half the time a robot tracking a drifting line (readings mirror each other around mid
    // scale), plus fully random pairs and rail-to-rail pairs that wrap the outputs.
    task automatic send_random_reading();
        int lft;
        int rgt;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            track_offset = track_offset + int'($urandom_range(0, 40)) - 20;
            if (track_offset > 127)
            begin
                track_offset = 127;
            end
            if (track_offset < -127)
            begin
                track_offset = -127;
            end
            lft = 128 + track_offset + int'($urandom_range(0, 7));
            rgt = 127 - track_offset + int'($urandom_range(0, 7));
            if (lft > 255)
            begin
                lft = 255;
            end
            if (rgt > 255)
            begin
                rgt = 255;
            end
        end
        else if (pick < 8)
        begin
            lft = $urandom_range(0, 255);
            rgt = $urandom_range(0, 255);
        end
        else
        begin
            lft = $urandom_range(0, 1) ? 255 : 0;
            rgt = $urandom_range(0, 1) ? 255 : 0;
        end
        send_reading(lft[RD_W-1:0], rgt[RD_W-1:0]);
    endtask

    // Drop valid, wait for every expected speed beat, then let the pipeline go quiet.
    task automatic drain_and_settle();
        sensor_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [GAIN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic write_gains(input logic [GAIN_W-1:0] base, input logic [GAIN_W-1:0] p,
                               input logic [GAIN_W-1:0] i, input logic [GAIN_W-1:0] a);
        write_reg(REG_BASE_SPEED, base);
        write_reg(REG_P_GAIN, p);
        write_reg(REG_I_GAIN, i);
        write_reg(REG_AVG_GAIN, a);
        cfg_we <= 1'b0;
        gain_settings++;
    endtask

    initial
    begin
        sensor_ch.valid         <= 1'b0;
        sensor_ch.left_reading  <= '0;
        sensor_ch.right_reading <= '0;
        cfg_we                  <= 1'b0;
        cfg_index               <= REG_BASE_SPEED;
        cfg_wdata               <= '0;
        rst_n                   <= 1'b0;
        tx_bursty     = 1'b1;
        rx_bursty     = 1'b1;
        hold_req      = 1'b0;
        sent_beats    = 0;
        gain_settings = 0;
        track_offset  = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset gains; the first beats see a window still padded with zeros from reset.
        send_reading(8'd0, 8'd0);
        send_reading(8'd255, 8'd0);
        send_reading(8'd0, 8'd255);
        send_reading(8'd255, 8'd255);
        send_reading(8'hAA, 8'h55);
        send_reading(8'h55, 8'hAA);
        send_reading(8'd128, 8'd127);
        send_reading(8'd127, 8'd128);
        drain_and_settle();

        // Every register at its top value: full-scale error drives both wheels past
        // the byte and wraps in each direction.
        write_gains(8'd255, 8'd255, 8'd255, 8'd255);
        send_reading(8'd255, 8'd0);
        send_reading(8'd255, 8'd0);
        send_reading(8'd0, 8'd255);
        send_reading(8'd0, 8'd255);
        send_reading(8'd0, 8'd0);
        send_reading(8'd255, 8'd255);
        drain_and_settle();

        // Everything at zero: outputs stay at zero whatever the readings.
        write_gains(8'd0, 8'd0, 8'd0, 8'd0);
        send_reading(8'd255, 8'd0);
        send_reading(8'd0, 8'd255);
        send_reading(8'h0F, 8'hF0);
        drain_and_settle();

        // One term at a time: integral-style pair, then the window average alone.
        write_gains(8'd100, 8'd0, 8'd255, 8'd0);
        send_reading(8'd200, 8'd10);
        send_reading(8'd10, 8'd200);
        drain_and_settle();
        write_gains(8'd100, 8'd0, 8'd0, 8'd255);
        send_reading(8'd255, 8'd0);
        send_reading(8'd255, 8'd0);
        send_reading(8'd0, 8'd255);
        drain_and_settle();

        // Random phases, each under its own gain setting. Phase 2 holds the speed channel
        // off for a long stretch; phase 4 and the final phase run with no idling at all.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain_and_settle();
            end
            case (phase)
                0: write_gains(BASE_SPEED_RST, P_GAIN_RST, I_GAIN_RST, AVG_GAIN_RST);
                2: write_gains(8'd255, GAIN_W'($urandom_range(0, 255)),
                               GAIN_W'($urandom_range(0, 255)),
                               GAIN_W'($urandom_range(0, 255)));
                3: write_gains(8'd0, 8'd255, 8'd255, 8'd255);
                default: write_gains(GAIN_W'($urandom_range(0, 255)),
                                     GAIN_W'($urandom_range(0, 255)),
                                     GAIN_W'($urandom_range(0, 255)),
                                     GAIN_W'($urandom_range(0, 255)));
            endcase
            tx_bursty = (phase != 4) && (phase != PHASES - 1);
            rx_bursty = tx_bursty;
            if (phase == 2)
            begin
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_random_reading();
        end

        // Flush: wait for the last speed beats and let the pipeline empty.
        drain_and_settle();

        $display("Summary: %0d sensor beats under %0d gain settings, %0d speed beats checked.",
                 sent_beats, gain_settings, results_checked);
        $display("Summary: random idling on both channels, a %0d-cycle speed stall, drains.",
                 LONG_HOLD);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
